>>> sv/iscv_pkg.sv
`timescale 1ns / 1ps

package iscv_pkg;

    localparam int VERSION_FIELD_BYTES = 16;
    localparam int NAME_FIELD_BYTES    = 32;
    localparam int SIZE_BITS           = 24;
    localparam int CFG_DATA_BITS       = 32;

    localparam int HDR_BYTES    = 48 + VERSION_FIELD_BYTES + NAME_FIELD_BYTES;
    localparam int RAM_FIELD_AT = 16 + VERSION_FIELD_BYTES + NAME_FIELD_BYTES;

    localparam logic [31:0] IMG_MAGIC       = 32'h5746_434D;
    localparam logic [15:0] IMG_HDR_VERSION = 16'd2;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_ABORT  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_INVALID    = 4'd1,
        ST_BUSY       = 4'd2,
        ST_TOO_BIG    = 4'd3,
        ST_NO_SPACE   = 4'd4,
        ST_INCOMPLETE = 4'd5,
        ST_BAD_HEADER = 4'd6,
        ST_BAD_CRC    = 4'd7,
        ST_RAM        = 4'd8,
        ST_ABORTED    = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        CFG_IMAGE_SIZE   = 2'd0,
        CFG_SLOT_SIZE    = 2'd1,
        CFG_STAGING_SIZE = 2'd2,
        CFG_RAM_LIMIT    = 2'd3
    } t_cfg_index;

    // Reflected CRC-32 update over one byte, one bit per step.
    function automatic logic [31:0] iscv_crc_byte(input logic [31:0] crc_in,
                                                  input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

>>> sv/image_store_header_crc_verifier.sv
`timescale 1ns / 1ps

// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+----------------------------------------
// input     | i_in_valid   | o_in_stall   | i_action, i_data_byte, i_byte_offset
// result    | o_out_valid  | i_out_stall  | o_status, o_session_open
// config    | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// One item is taken per cycle while o_in_stall is low; its result is registered in the
// result register, or in the skid register while the result register is held.
// A two-entry output buffer (result register plus skid register) lets a new item
// be taken while a result waits; o_in_stall rises only when both entries are full.
// Reset is synchronous and active low; it closes any session and restores the
// configuration registers to their defaults.

module image_store_header_crc_verifier (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  iscv_pkg::t_action        i_action,
    input  logic [7:0]               i_data_byte,
    input  logic [iscv_pkg::SIZE_BITS-1:0] i_byte_offset,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output iscv_pkg::t_status        o_status,
    output logic                     o_session_open,
    input  logic                     i_cfg_we,
    input  iscv_pkg::t_cfg_index     i_cfg_index,
    input  logic [iscv_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import iscv_pkg::*;

    localparam logic [SIZE_BITS-1:0] HDR_SZ  = SIZE_BITS'(HDR_BYTES);
    localparam logic [SIZE_BITS-1:0] RAM_AT  = SIZE_BITS'(RAM_FIELD_AT);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    // Configuration
    logic [SIZE_BITS-1:0] r_image_size;
    logic [SIZE_BITS-1:0] r_slot_size;
    logic [SIZE_BITS-1:0] r_staging_size;
    logic [31:0]          r_ram_limit;

    // Session state
    logic                 r_active,   n_active;
    logic [SIZE_BITS-1:0] r_received, n_received;
    logic [SIZE_BITS-1:0] r_sess_size, n_sess_size;
    logic [31:0]          r_crc,      n_crc;
    logic [31:0]          r_magic,    n_magic;
    logic [15:0]          r_version,  n_version;
    logic [15:0]          r_hdr_len,  n_hdr_len;
    logic [31:0]          r_pay_len,  n_pay_len;
    logic [31:0]          r_exp_crc,  n_exp_crc;
    logic [31:0]          r_ram_need, n_ram_need;
    t_status              n_status;

    // Output buffer
    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_open;
    logic                 r_skid_valid;
    t_status              r_skid_status;
    logic                 r_skid_open;

    logic                 in_xfer;
    logic                 out_free;
    logic [SIZE_BITS-1:0] pay_off;
    logic [SIZE_BITS-1:0] ram_rel;

    assign o_in_stall     = r_skid_valid;
    assign in_xfer        = i_in_valid && !r_skid_valid;
    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_session_open = r_out_open;
    assign pay_off        = i_byte_offset - HDR_SZ;
    assign ram_rel        = i_byte_offset - RAM_AT;

    always_comb begin
        n_active    = r_active;
        n_received  = r_received;
        n_sess_size = r_sess_size;
        n_crc       = r_crc;
        n_magic     = r_magic;
        n_version   = r_version;
        n_hdr_len   = r_hdr_len;
        n_pay_len   = r_pay_len;
        n_exp_crc   = r_exp_crc;
        n_ram_need  = r_ram_need;
        n_status    = ST_OK;

        unique case (i_action)
            ACT_START: begin
                if (r_image_size < HDR_SZ) begin
                    n_status = ST_INVALID;
                end else if (r_active) begin
                    n_status = ST_BUSY;
                end else begin
                    n_received = '0;
                    n_crc      = CRC_PRESET;
                    n_magic    = '0;
                    n_version  = '0;
                    n_hdr_len  = '0;
                    n_pay_len  = '0;
                    n_exp_crc  = '0;
                    n_ram_need = '0;
                    n_sess_size = '0;
                    if (r_image_size > r_slot_size) begin
                        n_status = ST_TOO_BIG;
                    end else if (r_image_size > r_staging_size) begin
                        n_status = ST_NO_SPACE;
                    end else begin
                        n_sess_size = r_image_size;
                        n_active    = 1'b1;
                    end
                end
            end
            ACT_DATA: begin
                if (!r_active || i_byte_offset != r_received) begin
                    n_status = ST_INVALID;
                end else if (r_received >= r_sess_size) begin
                    n_status = ST_TOO_BIG;
                end else begin
                    n_received = r_received + SIZE_BITS'(1);
                    // The header fields are little endian; the low offset bits pick the lane.
                    if (i_byte_offset < SIZE_BITS'(4)) begin
                        n_magic[8*i_byte_offset[1:0] +: 8] = i_data_byte;
                    end else if (i_byte_offset < SIZE_BITS'(6)) begin
                        n_version[8*i_byte_offset[0] +: 8] = i_data_byte;
                    end else if (i_byte_offset < SIZE_BITS'(8)) begin
                        n_hdr_len[8*i_byte_offset[0] +: 8] = i_data_byte;
                    end else if (i_byte_offset < SIZE_BITS'(12)) begin
                        n_pay_len[8*i_byte_offset[1:0] +: 8] = i_data_byte;
                    end else if (i_byte_offset < SIZE_BITS'(16)) begin
                        n_exp_crc[8*i_byte_offset[1:0] +: 8] = i_data_byte;
                    end else if (i_byte_offset >= RAM_AT &&
                                 i_byte_offset < RAM_AT + SIZE_BITS'(4)) begin
                        n_ram_need[8*ram_rel[1:0] +: 8] = i_data_byte;
                    end else if (i_byte_offset >= HDR_SZ &&
                                 32'(pay_off) < r_pay_len) begin
                        n_crc = iscv_crc_byte(r_crc, i_data_byte);
                    end
                end
            end
            ACT_FINISH: begin
                if (!r_active) begin
                    n_status = ST_INVALID;
                end else begin
                    if (r_received != r_sess_size) begin
                        n_status = ST_INCOMPLETE;
                    end else if (r_magic != IMG_MAGIC || r_version != IMG_HDR_VERSION ||
                                 r_hdr_len != 16'(HDR_BYTES) || r_pay_len == '0 ||
                                 r_pay_len > 32'(r_sess_size - HDR_SZ)) begin
                        n_status = ST_BAD_HEADER;
                    end else if (r_ram_need > r_ram_limit) begin
                        n_status = ST_RAM;
                    end else if (~r_crc != r_exp_crc) begin
                        n_status = ST_BAD_CRC;
                    end
                    n_active    = 1'b0;
                    n_received  = '0;
                    n_sess_size = '0;
                    n_crc       = CRC_PRESET;
                    n_magic     = '0;
                    n_version   = '0;
                    n_hdr_len   = '0;
                    n_pay_len   = '0;
                    n_exp_crc   = '0;
                    n_ram_need  = '0;
                end
            end
            ACT_ABORT: begin
                if (!r_active) begin
                    n_status = ST_INVALID;
                end else begin
                    n_status    = ST_ABORTED;
                    n_active    = 1'b0;
                    n_received  = '0;
                    n_sess_size = '0;
                    n_crc       = CRC_PRESET;
                    n_magic     = '0;
                    n_version   = '0;
                    n_hdr_len   = '0;
                    n_pay_len   = '0;
                    n_exp_crc   = '0;
                    n_ram_need  = '0;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size   <= '0;
            r_slot_size    <= SIZE_MAX;
            r_staging_size <= SIZE_MAX;
            r_ram_limit    <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIZE:   r_image_size   <= i_cfg_data[SIZE_BITS-1:0];
                CFG_SLOT_SIZE:    r_slot_size    <= i_cfg_data[SIZE_BITS-1:0];
                CFG_STAGING_SIZE: r_staging_size <= i_cfg_data[SIZE_BITS-1:0];
                CFG_RAM_LIMIT:    r_ram_limit    <= i_cfg_data[31:0];
                default:          r_ram_limit    <= r_ram_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_received  <= '0;
            r_sess_size <= '0;
            r_crc       <= CRC_PRESET;
            r_magic     <= '0;
            r_version   <= '0;
            r_hdr_len   <= '0;
            r_pay_len   <= '0;
            r_exp_crc   <= '0;
            r_ram_need  <= '0;
        end else if (in_xfer) begin
            r_active    <= n_active;
            r_received  <= n_received;
            r_sess_size <= n_sess_size;
            r_crc       <= n_crc;
            r_magic     <= n_magic;
            r_version   <= n_version;
            r_hdr_len   <= n_hdr_len;
            r_pay_len   <= n_pay_len;
            r_exp_crc   <= n_exp_crc;
            r_ram_need  <= n_ram_need;
        end
    end

    // The skid register fills only while the result register is held, and it
    // drains into the result register before any new item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_open   <= r_skid_open;
            end else if (in_xfer) begin
                r_out_status <= n_status;
                r_out_open   <= n_active;
            end
        end else if (in_xfer) begin
            r_skid_status <= n_status;
            r_skid_open   <= n_active;
        end
    end

endmodule
